// ===== rtl/glb_container_deframer_defines.svh =====
// Assertion macros for the GLB container deframer.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef GLB_CONTAINER_DEFRAMER_DEFINES_SVH
`define GLB_CONTAINER_DEFRAMER_DEFINES_SVH

// same-cycle implication
`define GLBD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GLBD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/glbd_pkg.sv =====
// Package for the GLB container deframer: payload types, result codes,
// container constants. No dependencies.
`default_nettype none

package glbd_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int MAX_RES         = 3;

    localparam logic [31:0] CONTAINER_MAGIC = 32'h4654_6C67;
    localparam logic [31:0] GLB_VERSION = 32'd2;
    localparam logic [31:0] HDR_BYTES   = 32'd12;
    localparam logic [31:0] CHDR_BYTES  = 32'd8;
    localparam logic [31:0] WORD_BYTES  = 32'd4;
    localparam logic [31:0] MAGIC_END   = 32'd4;
    localparam logic [31:0] VERSION_END = 32'd8;

    localparam logic [31:0] JSON_TYPE_RST = 32'h4E4F_534A;
    localparam logic [31:0] BIN_TYPE_RST  = 32'h004E_4942;

    // configuration register indexes
    localparam logic REG_JSON_TYPE = 1'b0;
    localparam logic REG_BIN_TYPE  = 1'b1;

    // result kinds
    localparam logic [1:0] K_DATA   = 2'd0;
    localparam logic [1:0] K_ACCEPT = 2'd1;
    localparam logic [1:0] K_DONE   = 2'd2;
    localparam logic [1:0] K_ERROR  = 2'd3;

    // fault codes
    localparam logic [2:0] F_HDR_SHORT  = 3'd0;
    localparam logic [2:0] F_MAGIC      = 3'd1;
    localparam logic [2:0] F_VERSION    = 3'd2;
    localparam logic [2:0] F_LENGTH     = 3'd3;
    localparam logic [2:0] F_CHDR_SHORT = 3'd4;
    localparam logic [2:0] F_DATA_SHORT = 3'd5;
    localparam logic [2:0] F_TYPE       = 3'd6;
    localparam logic [2:0] F_ZERO_LEN   = 3'd7;

    // chunk classes
    localparam logic [1:0] CK_JSON = 2'd0;
    localparam logic [1:0] CK_BIN  = 2'd1;
    localparam logic [1:0] CK_UNK  = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_final;
    } in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic        chunk_kind;
        logic [31:0] chunk_size;
        logic [2:0]  fault;
        logic        run_end;
    } res_t;

    // all results caused by one input byte
    typedef struct packed {
        logic [1:0]         cnt;
        res_t [MAX_RES-1:0] res;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } enq_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic res_t mk_res(logic [1:0] kind, logic [7:0] byte_val,
                                    logic ck, logic [31:0] size, logic [2:0] fault);
        res_t r;
        r.kind       = kind;
        r.out_byte   = byte_val;
        r.chunk_kind = ck;
        r.chunk_size = size;
        r.fault      = fault;
        r.run_end    = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/glbd_front.sv =====
// Front end of the GLB deframer: type registers, container/chunk parser,
// builds one queue entry per byte. Depends on glbd_pkg.
`default_nettype none

module glbd_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire glbd_pkg::in_t   item,
    input  wire glbd_pkg::q_stat_t stat,
    output glbd_pkg::enq_t       enq,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic            cfg_index,
    input  wire logic [31:0]     cfg_data
);
    import glbd_pkg::*;

    localparam logic [2:0] PH_HDR  = 3'd0;
    localparam logic [2:0] PH_CHDR = 3'd1;
    localparam logic [2:0] PH_DATA = 3'd2;
    localparam logic [2:0] PH_PAD  = 3'd3;
    localparam logic [2:0] PH_ERR  = 3'd4;

    logic [31:0] json_type_reg;
    logic [31:0] bin_type_reg;

    logic [2:0]  phase_reg, phase_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [31:0] word_reg, word_next;
    logic [31:0] len_reg, len_next;
    logic [1:0]  ck_reg, ck_next;
    logic [1:0]  pad_reg, pad_next;

    logic        accept;
    logic        fin;
    logic        clr;
    logic [1:0]  res_cnt;
    entry_t      entry;

    assign cfg_ready = 1'b1;
    assign accept    = push && !stat.full;
    assign fin       = item.is_final;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            json_type_reg <= JSON_TYPE_RST;
            bin_type_reg  <= BIN_TYPE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_JSON_TYPE: json_type_reg <= cfg_data;
                REG_BIN_TYPE:  bin_type_reg  <= cfg_data;
            endcase
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        word_next  = word_reg;
        len_next   = len_reg;
        ck_next    = ck_reg;
        pad_next   = pad_reg;
        clr        = 1'b0;
        res_cnt    = 2'd0;
        entry      = '0;

        unique case (phase_reg)
            PH_HDR:
            begin
                word_next = {item.in_byte, word_reg[31:8]};
                cnt_next  = cnt_reg + 32'd1;
                if (cnt_next == MAGIC_END && word_next != CONTAINER_MAGIC)
                    ck_next[0] = 1'b1;
                if (cnt_next == VERSION_END && word_next != GLB_VERSION)
                    ck_next[1] = 1'b1;
                if (cnt_next == HDR_BYTES)
                begin
                    if (ck_next[0] || ck_next[1] || word_next < HDR_BYTES)
                    begin
                        // magic first, then version, then length
                        entry.res[res_cnt] = mk_res(K_ERROR, 8'd0, 1'b0, 32'd0,
                            ck_next[0] ? F_MAGIC : (ck_next[1] ? F_VERSION : F_LENGTH));
                        res_cnt    = res_cnt + 2'd1;
                        phase_next = PH_ERR;
                        clr        = fin;
                    end
                    else if (fin)
                    begin
                        entry.res[res_cnt] = mk_res(K_DONE, 8'd0, 1'b0, 32'd0, 3'd0);
                        res_cnt = res_cnt + 2'd1;
                        clr     = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_CHDR;
                        cnt_next   = 32'd0;
                        ck_next    = CK_JSON;
                    end
                end
                else if (fin)
                begin
                    entry.res[res_cnt] = mk_res(K_ERROR, 8'd0, 1'b0, 32'd0, F_HDR_SHORT);
                    res_cnt = res_cnt + 2'd1;
                    clr     = 1'b1;
                end
            end
            PH_CHDR:
            begin
                word_next = {item.in_byte, word_reg[31:8]};
                cnt_next  = cnt_reg + 32'd1;
                if (cnt_next == WORD_BYTES)
                    len_next = word_next;
                if (cnt_next == CHDR_BYTES)
                begin
                    if (word_next == json_type_reg)
                        ck_next = CK_JSON;
                    else if (word_next == bin_type_reg)
                        ck_next = CK_BIN;
                    else
                        ck_next = CK_UNK;
                    if (len_next == 32'd0)
                    begin
                        entry.res[res_cnt] = mk_res(K_ERROR, 8'd0, 1'b0, 32'd0,
                            (ck_next == CK_UNK) ? F_TYPE : F_ZERO_LEN);
                        res_cnt    = res_cnt + 2'd1;
                        phase_next = PH_ERR;
                        clr        = fin;
                    end
                    else if (fin)
                    begin
                        entry.res[res_cnt] = mk_res(K_ERROR, 8'd0, 1'b0, 32'd0,
                            F_DATA_SHORT);
                        res_cnt = res_cnt + 2'd1;
                        clr     = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                        cnt_next   = 32'd0;
                    end
                end
                else if (fin)
                begin
                    entry.res[res_cnt] = mk_res(K_ERROR, 8'd0, 1'b0, 32'd0, F_CHDR_SHORT);
                    res_cnt = res_cnt + 2'd1;
                    clr     = 1'b1;
                end
            end
            PH_DATA:
            begin
                entry.res[res_cnt] = mk_res(K_DATA, item.in_byte, ck_reg == CK_BIN,
                    32'd0, 3'd0);
                res_cnt  = res_cnt + 2'd1;
                cnt_next = cnt_reg + 32'd1;
                if (cnt_next == len_reg)
                begin
                    if (ck_reg == CK_UNK)
                    begin
                        entry.res[res_cnt] = mk_res(K_ERROR, 8'd0, 1'b0, 32'd0, F_TYPE);
                        res_cnt    = res_cnt + 2'd1;
                        phase_next = PH_ERR;
                        clr        = fin;
                    end
                    else
                    begin
                        entry.res[res_cnt] = mk_res(K_ACCEPT, 8'd0, ck_reg[0], len_reg,
                            3'd0);
                        res_cnt  = res_cnt + 2'd1;
                        pad_next = 2'd0 - len_reg[1:0];
                        if (fin)
                        begin
                            entry.res[res_cnt] = mk_res(K_DONE, 8'd0, 1'b0, 32'd0, 3'd0);
                            res_cnt = res_cnt + 2'd1;
                            clr     = 1'b1;
                        end
                        else if (pad_next != 2'd0)
                            phase_next = PH_PAD;
                        else
                        begin
                            phase_next = PH_CHDR;
                            cnt_next   = 32'd0;
                        end
                    end
                end
                else if (fin)
                begin
                    entry.res[res_cnt] = mk_res(K_ERROR, 8'd0, 1'b0, 32'd0, F_DATA_SHORT);
                    res_cnt = res_cnt + 2'd1;
                    clr     = 1'b1;
                end
            end
            PH_PAD:
            begin
                pad_next = pad_reg - 2'd1;
                if (fin)
                begin
                    entry.res[res_cnt] = mk_res(K_DONE, 8'd0, 1'b0, 32'd0, 3'd0);
                    res_cnt = res_cnt + 2'd1;
                    clr     = 1'b1;
                end
                else if (pad_next == 2'd0)
                begin
                    phase_next = PH_CHDR;
                    cnt_next   = 32'd0;
                end
            end
            default:
            begin
                // error phase and unused codes: swallow up to the final byte
                phase_next = PH_ERR;
                clr        = fin;
            end
        endcase

        if (res_cnt != 2'd0)
            entry.res[res_cnt - 2'd1].run_end = 1'b1;
        entry.cnt = res_cnt;

        if (clr)
        begin
            phase_next = PH_HDR;
            cnt_next   = 32'd0;
            word_next  = 32'd0;
            len_next   = 32'd0;
            ck_next    = 2'd0;
            pad_next   = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR;
            cnt_reg   <= 32'd0;
            word_reg  <= 32'd0;
            len_reg   <= 32'd0;
            ck_reg    <= 2'd0;
            pad_reg   <= 2'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            word_reg  <= word_next;
            len_reg   <= len_next;
            ck_reg    <= ck_next;
            pad_reg   <= pad_next;
        end
    end

    // bytes with no result never take a queue slot
    assign enq.valid = accept && (res_cnt != 2'd0);
    assign enq.entry = entry;

endmodule

`default_nettype wire

// ===== rtl/glbd_queue.sv =====
// Entry queue between deframer front and back ends.
// Depends on glbd_pkg.
`default_nettype none

module glbd_queue #(
    parameter int QUEUE_DEPTH = glbd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire glbd_pkg::enq_t    enq,
    input  wire logic              deq,
    output glbd_pkg::entry_t       head,
    output glbd_pkg::q_stat_t      stat
);
    import glbd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_wr;
    logic               do_rd;

    assign stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_wr      = enq.valid && !stat.full;
    assign do_rd      = deq && !stat.empty;
    assign head       = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= enq.entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/glbd_back.sv =====
// Back end of the GLB deframer: walks the results of the head entry,
// one per output beat. Depends on glbd_pkg.
`default_nettype none

module glbd_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire glbd_pkg::entry_t  head,
    input  wire glbd_pkg::q_stat_t stat,
    input  wire logic              pop,
    output glbd_pkg::res_t         result,
    output logic                   empty,
    output logic                   deq
);
    import glbd_pkg::*;

    logic [1:0] idx_reg;
    logic       take;
    logic       last;

    assign empty  = stat.empty;
    assign result = head.res[idx_reg];
    assign take   = pop && !stat.empty;
    assign last   = ((idx_reg + 2'd1) == head.cnt);
    assign deq    = take && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 2'd0;
        else if (take)
            idx_reg <= last ? 2'd0 : idx_reg + 2'd1;
    end

endmodule

`default_nettype wire

// ===== rtl/glb_container_deframer.sv =====
// Top level of the GLB container deframer: front parser, entry queue, back end.
// Depends on glbd_pkg, glbd_front, glbd_queue, glbd_back and the defines header.
//
//  channel   ports                                  beat taken when
//  -------   -------------------------------------  ------------------------
//  input     item, push, full                       push && !full
//  result    result, empty, pop                     pop && !empty
//  config    cfg_index, cfg_data, cfg_valid/ready   cfg_valid && cfg_ready
//
// One input byte per cycle while the queue is not full; a byte that
// causes two or three results takes that many result beats to pop.
// The entry queue (QUEUE_DEPTH entries) lets the parser run ahead of pop.
// Bytes with no result (header, padding, after an error) never enter the queue.
// rst_n clears parser state, queue pointers and loads the default type words.
// No clearing pass after reset; config writes are registered on the edge that takes them.
`default_nettype none
`include "glb_container_deframer_defines.svh"

module glb_container_deframer #(
    parameter int QUEUE_DEPTH = glbd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire glbd_pkg::in_t  item,
    output logic                empty,
    input  wire logic           pop,
    output glbd_pkg::res_t      result,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic           cfg_index,
    input  wire logic [31:0]    cfg_data
);
    import glbd_pkg::*;

    enq_t    enq;
    q_stat_t stat;
    entry_t  head;
    logic    deq;

    assign full = stat.full;

    glbd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .stat      (stat),
        .enq       (enq),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    glbd_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .enq   (enq),
        .deq   (deq),
        .head  (head),
        .stat  (stat)
    );

    glbd_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .stat   (stat),
        .pop    (pop),
        .result (result),
        .empty  (empty),
        .deq    (deq)
    );

    `GLBD_ASSERT_IMP(a_full_not_empty, full, !empty, "queue full and empty at once")
    `GLBD_ASSERT_IMP(a_fault_zero, !empty && result.kind != K_ERROR, result.fault == 3'd0, "fault set on non-error result")
    `GLBD_ASSERT_NXT(a_run_continues, pop && !empty && !result.run_end, !empty, "result run broken before run_end")

endmodule

`default_nettype wire

// ===== test/glbd_result_checker.sv =====
// Result checker for the GLB container deframer testbench.
// Watches the input, result and register channels; depends on glbd_pkg only.
module glbd_result_checker
    import glbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  in_t         item,
    input  logic        empty,
    input  logic        pop,
    input  res_t        result,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output int unsigned errors,
    output int unsigned pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {S_HDR, S_CHDR, S_DATA, S_PAD, S_ERR} parse_state_e;

    localparam logic [2:0] NO_FAULT = 3'd0;

    logic [31:0]  json_word;
    logic [31:0]  bin_word;
    parse_state_e state;
    logic [31:0]  taken;
    logic [31:0]  shift_word;
    logic [31:0]  chunk_len;
    logic [1:0]   chunk_class;  // header: bit0 bad magic, bit1 bad version
    logic [1:0]   pad_left;
    res_t         step_out[$];
    res_t         awaited[$];

    function automatic void reset_parse();
        state       = S_HDR;
        taken       = 32'd0;
        shift_word  = 32'd0;
        chunk_len   = 32'd0;
        chunk_class = CK_JSON;
        pad_left    = 2'd0;
    endfunction

    function automatic void emit_result(input logic [1:0] k, input logic [7:0] b,
                                        input logic ck, input logic [31:0] size,
                                        input logic [2:0] f);
        res_t r;
        r.kind       = k;
        r.out_byte   = b;
        r.chunk_kind = ck;
        r.chunk_size = size;
        r.fault      = f;
        r.run_end    = 1'b0;
        step_out.insert(step_out.size(), r);
    endfunction

    function automatic void flag_fault(input logic [2:0] f, input logic fin);
        emit_result(K_ERROR, 8'h00, 1'b0, 32'd0, f);
        if (fin)
            reset_parse();
        else
            state = S_ERR;
    endfunction

    function automatic void close_container();
        emit_result(K_DONE, 8'h00, 1'b0, 32'd0, NO_FAULT);
        reset_parse();
    endfunction

    // expected results of one input beat, appended to the awaited queue
    function automatic void parse_byte(input in_t it);
        logic [7:0] b;
        logic       fin;
        res_t       last;
        b   = it.in_byte;
        fin = it.is_final;
        step_out.delete();
        case (state)
            S_HDR:
            begin
                shift_word = {b, shift_word[31:8]};
                taken      = taken + 32'd1;
                if (taken == MAGIC_END && shift_word != CONTAINER_MAGIC)
                    chunk_class[0] = 1'b1;
                if (taken == VERSION_END && shift_word != GLB_VERSION)
                    chunk_class[1] = 1'b1;
                if (taken == HDR_BYTES)
                begin
                    if (chunk_class[0])
                        flag_fault(F_MAGIC, fin);
                    else if (chunk_class[1])
                        flag_fault(F_VERSION, fin);
                    else if (shift_word < HDR_BYTES)
                        flag_fault(F_LENGTH, fin);
                    else if (fin)
                        close_container();
                    else
                    begin
                        state       = S_CHDR;
                        taken       = 32'd0;
                        chunk_class = CK_JSON;
                    end
                end
                else if (fin)
                    flag_fault(F_HDR_SHORT, fin);
            end
            S_CHDR:
            begin
                shift_word = {b, shift_word[31:8]};
                taken      = taken + 32'd1;
                if (taken == WORD_BYTES)
                    chunk_len = shift_word;
                if (taken == CHDR_BYTES)
                begin
                    // JSON wins when both codes match
                    if (shift_word == json_word)
                        chunk_class = CK_JSON;
                    else if (shift_word == bin_word)
                        chunk_class = CK_BIN;
                    else
                        chunk_class = CK_UNK;
                    if (chunk_len == 32'd0)
                        flag_fault(chunk_class == CK_UNK ? F_TYPE : F_ZERO_LEN, fin);
                    else if (fin)
                        flag_fault(F_DATA_SHORT, fin);
                    else
                    begin
                        state = S_DATA;
                        taken = 32'd0;
                    end
                end
                else if (fin)
                    flag_fault(F_CHDR_SHORT, fin);
            end
            S_DATA:
            begin
                emit_result(K_DATA, b, chunk_class == CK_BIN, 32'd0, NO_FAULT);
                taken = taken + 32'd1;
                if (taken == chunk_len)
                begin
                    if (chunk_class == CK_UNK)
                        flag_fault(F_TYPE, fin);
                    else
                    begin
                        emit_result(K_ACCEPT, 8'h00, chunk_class[0], chunk_len, NO_FAULT);
                        pad_left = 2'd0 - chunk_len[1:0];
                        if (fin)
                            close_container();
                        else if (pad_left != 2'd0)
                            state = S_PAD;
                        else
                        begin
                            state = S_CHDR;
                            taken = 32'd0;
                        end
                    end
                end
                else if (fin)
                    flag_fault(F_DATA_SHORT, fin);
            end
            S_PAD:
            begin
                pad_left = pad_left - 2'd1;
                if (fin)
                    close_container();
                else if (pad_left == 2'd0)
                begin
                    state = S_CHDR;
                    taken = 32'd0;
                end
            end
            default:
            begin
                if (fin)
                    reset_parse();
            end
        endcase
        if (step_out.size() > 0)
        begin
            last = step_out.pop_back();
            last.run_end = 1'b1;
            step_out.insert(step_out.size(), last);
        end
        foreach (step_out[i])
            awaited.insert(awaited.size(), step_out[i]);
    endfunction

    function automatic void check_result(input res_t got);
        res_t want;
        if (awaited.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: kind %0d byte %02h class %0d size %08h fault %0d",
                         got.kind, got.out_byte, got.chunk_kind, got.chunk_size, got.fault);
            return;
        end
        want = awaited.pop_front();
        if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
            got.chunk_kind !== want.chunk_kind || got.chunk_size !== want.chunk_size ||
            got.fault !== want.fault || got.run_end !== want.run_end)
        begin
            errors++;
            if (errors <= 10)
            begin
                $display("result mismatch");
                $display("  expected kind %0d byte %02h class %0d size %08h fault %0d end %0b",
                         want.kind, want.out_byte, want.chunk_kind, want.chunk_size,
                         want.fault, want.run_end);
                $display("  got      kind %0d byte %02h class %0d size %08h fault %0d end %0b",
                         got.kind, got.out_byte, got.chunk_kind, got.chunk_size,
                         got.fault, got.run_end);
            end
        end
    endfunction

    // results of a beat never come out on the edge that takes it, so the
    // result side is checked before the input side is predicted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            json_word = JSON_TYPE_RST;
            bin_word  = BIN_TYPE_RST;
            reset_parse();
            awaited.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (pop && !empty)
                check_result(result);
            if (push && !full)
                parse_byte(item);
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_JSON_TYPE)
                    json_word = cfg_data;
                else
                    bin_word = cfg_data;
            end
            pending = awaited.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
// Top of the GLB container deframer testbench: clock, reset, stimulus, verdict.
// Depends on glbd_pkg, glb_container_deframer and glbd_result_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import glbd_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 8;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    in_t         item;
    logic        empty;
    logic        pop;
    res_t        result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;
    int unsigned errors;
    int unsigned pending;

    bit          gaps_on = 1'b1;
    int unsigned hold_reqs = 0;
    int unsigned sent = 0;
    int unsigned idle_cycles = 0;
    logic [31:0] json_now;
    logic [31:0] bin_now;
    logic [7:0]  stream[$];

    glb_container_deframer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    glbd_result_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // result side; a hold request stalls pop for a long stretch
    initial
    begin : receiver
        int unsigned seen;
        int unsigned left;
        seen = 0;
        left = 0;
        pop  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (seen != hold_reqs)
            begin
                seen = hold_reqs;
                left = HOLD_CYCLES;
            end
            if (left > 0)
            begin
                left--;
                pop <= 1'b0;
            end
            else
                pop <= !gaps_on || ($urandom_range(99) >= 25);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic logic [7:0] rand_byte();
        logic [31:0] r;
        r = $urandom;
        return r[7:0];
    endfunction

    // type word matching neither register
    function automatic logic [31:0] odd_word();
        logic [31:0] w;
        do
            w = $urandom;
        while (w == json_now || w == bin_now);
        return w;
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        stream.insert(stream.size(), b);
    endfunction

    function automatic void put_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            add_byte(w[8*i +: 8]);
    endfunction

    function automatic void begin_glb(input logic [31:0] len);
        stream.delete();
        put_word(CONTAINER_MAGIC);
        put_word(GLB_VERSION);
        put_word(len);
    endfunction

    // chunk header, payload and full padding; fill < 0 gives random bytes
    function automatic void put_chunk(input logic [31:0] len, input logic [31:0] ty,
                                      input int fill);
        int unsigned total;
        logic [31:0] f;
        put_word(len);
        put_word(ty);
        f = fill;
        total = len + ((4 - len % 4) % 4);
        for (int unsigned i = 0; i < total; i++)
            add_byte(fill < 0 ? rand_byte() : f[7:0]);
    endfunction

    function automatic void cut_to(input int unsigned n);
        while (stream.size() > n)
            void'(stream.pop_back());
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin);
        in_t v;
        @(negedge clk);
        while (gaps_on && $urandom_range(99) < 25)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        v.in_byte  = b;
        v.is_final = fin;
        push <= 1'b1;
        item <= v;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sent++;
    endtask

    // whole buffer, final flag on the last byte
    task automatic send_stream();
        foreach (stream[i])
            send_byte(stream[i], i == stream.size() - 1);
    endtask

    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_JSON_TYPE)
            json_now = val;
        else
            bin_now = val;
    endtask

    task automatic set_codes(input logic [31:0] js, input logic [31:0] bn);
        write_reg(REG_JSON_TYPE, js);
        write_reg(REG_BIN_TYPE, bn);
    endtask

    // mostly well-formed containers, some corrupted, cut short or overlong
    task automatic rand_container();
        logic [31:0] len;
        logic [31:0] ty;
        int unsigned nchunks;
        int unsigned r;
        int unsigned idx;
        len = $urandom;
        if ($urandom_range(9) == 0)
            len = $urandom_range(11);
        else if (len < HDR_BYTES)
            len = HDR_BYTES;
        begin_glb(len);
        nchunks = $urandom_range(3);
        for (int unsigned c = 0; c < nchunks; c++)
        begin
            r = $urandom_range(9);
            ty = r < 4 ? json_now : (r < 8 ? bin_now : odd_word());
            put_chunk($urandom_range(9) == 0 ? 0 : $urandom_range(7, 1), ty, -1);
        end
        r = $urandom_range(99);
        if (r < 6)
        begin
            idx = $urandom_range(11);
            stream[idx] = stream[idx] ^ (8'h01 << $urandom_range(7));
        end
        else if (r < 12)
        begin
            idx = $urandom_range(stream.size() - 1);
            stream[idx] = stream[idx] ^ (8'h01 << $urandom_range(7));
        end
        else if (r < 30)
            cut_to($urandom_range(stream.size(), 1));
        else if (r < 36)
        begin
            r = $urandom_range(9, 1);
            repeat (r) add_byte(rand_byte());
        end
        send_stream();
    endtask

    task automatic random_run(input int unsigned n);
        int unsigned stop;
        stop = sent + n;
        while (sent < stop)
            rand_container();
    endtask

    initial
    begin : stimulus
        logic [31:0] w;
        rst_n     = 1'b0;
        push      = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_JSON_TYPE;
        cfg_data  = 32'd0;
        json_now  = JSON_TYPE_RST;
        bin_now   = BIN_TYPE_RST;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // header only, minimum length
        begin_glb(HDR_BYTES);
        send_stream();
        // header cut short, on the first byte and mid-version
        begin_glb(HDR_BYTES);
        cut_to(1);
        send_stream();
        begin_glb(HDR_BYTES);
        cut_to(7);
        send_stream();
        // bad magic and bad version: magic reported
        stream.delete();
        put_word(32'd0);
        put_word(32'd3);
        put_word(32'd100);
        send_stream();
        // bad version only
        stream.delete();
        put_word(CONTAINER_MAGIC);
        put_word(32'd1);
        put_word(32'd100);
        send_stream();
        // length too small, rest of the buffer ignored
        begin_glb(HDR_BYTES - 1);
        add_byte(rand_byte());
        send_stream();
        // JSON then binary, final on the last data byte: data, accept, done
        begin_glb(32'hFFFF_FFFF);
        put_chunk(32'd3, json_now, 8'h00);
        put_chunk(32'd4, bin_now, 8'hFF);
        send_stream();
        // chunk header cut short
        begin_glb(32'd40);
        put_word(32'd5);
        add_byte(8'h4A);
        add_byte(8'h53);
        send_stream();
        // zero length, unknown type, then junk up to the final byte
        begin_glb(32'd40);
        put_chunk(32'd0, odd_word(), -1);
        add_byte(rand_byte());
        send_stream();
        // chunk header ends on the final byte
        begin_glb(32'd40);
        put_word(32'd4);
        put_word(json_now);
        send_stream();
        // data cut short
        begin_glb(32'd40);
        put_chunk(32'd6, json_now, -1);
        cut_to(HDR_BYTES + CHDR_BYTES + 3);
        send_stream();
        // unknown type streams its payload, then errors; trailing bytes ignored
        begin_glb(32'd40);
        put_chunk(32'd2, odd_word(), -1);
        add_byte(rand_byte());
        send_stream();
        // final inside the padding
        begin_glb(32'd40);
        put_chunk(32'd1, json_now, -1);
        cut_to(stream.size() - 1);
        send_stream();
        // huge declared length, cut short
        begin_glb(32'd60);
        put_word(32'hFFFF_FFFF);
        put_word(bin_now);
        add_byte(8'hFF);
        add_byte(8'h00);
        send_stream();
        drain();

        // extreme type words, zero length JSON on the final byte
        set_codes(32'h0000_0000, 32'hFFFF_FFFF);
        begin_glb(32'd60);
        put_chunk(32'd2, 32'hFFFF_FFFF, 8'hFF);
        put_chunk(32'd0, 32'h0000_0000, -1);
        send_stream();
        drain();

        // receiver holds off while the sender keeps offering a long chunk
        set_codes($urandom, $urandom);
        hold_reqs++;
        begin_glb(32'd60);
        put_chunk(32'd8, bin_now, -1);
        send_stream();
        drain();

        // equal type words: JSON wins; no idling on either side
        w = $urandom;
        set_codes(w, w);
        gaps_on = 1'b0;
        random_run(30);
        gaps_on = 1'b1;
        drain();

        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
